// ===== rtl/pnnc_pkg.sv =====
// ----------------------------------------------------------------------------
// pnnc_pkg
// Shared types, widths and controller/datapath command and status groups
// for the polygon Newell normal and centroid unit.
// ----------------------------------------------------------------------------
package pnnc_pkg;

    localparam int POS_W        = 24;   // corner coordinate width
    localparam int NSUM_W       = 59;   // Newell sum width (wraps)
    localparam int CSUM_W       = 33;   // coordinate sum width (wraps)
    localparam int FACE_W       = 16;
    localparam int NRM_W        = 16;   // Q1.14 normal component
    localparam int TOT_W        = 8;
    localparam int CNTX_W       = 17;   // holds the corner count for MAX_CORNERS up to 131070
    localparam int MUL_W        = 32;   // shared multiplier operand width
    localparam int PROD_W       = 64;
    localparam int MAG_SIG_W    = 30;   // normalised magnitude width
    localparam int SQ_W         = 62;   // sum of three squares
    localparam int ROOT_W       = 64;
    localparam int DEN_W        = 32;
    localparam int NUM_W        = 48;   // divider dividend width = steps
    localparam int SQRT_STEPS   = 32;
    localparam int DIV_STEPS    = NUM_W;
    localparam int NRM_FRAC     = 14;
    localparam int NUM_DIVS     = 6;    // three normal, three centroid
    localparam int MAX_CORNERS_DEF = 255;

    typedef logic signed [POS_W-1:0] t_pos;

    typedef struct packed {
        logic       load_in;     // capture accepted corner
        logic       first_ld;    // start a polygon with this corner
        logic       mul_en;      // register shared multiplier output
        logic       mul_sq;      // multiplier squares a magnitude
        logic       edge_first;  // edge runs to first corner (closing edge)
        logic       acc_newell;  // add product to Newell sum
        logic       acc_sq;      // add product to sum of squares
        logic       upd;         // coordinate sum, previous corner, count
        logic       cnt_sat;     // count beyond the limit
        logic       res_clr;
        logic       mag_ld;
        logic       norm_step;
        logic       sq_clr;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       div_ld;
        logic       div_step;
        logic       div_store;
        logic       emit;        // load output register, close polygon
        logic [2:0] idx;
    } t_cmd;

    typedef struct packed {
        logic cnt_zero;
        logic cnt_lt_max;
        logic cnt_ovf;
        logic nsum_zero;
        logic norm_done;
        logic out_busy;
    } t_sts;

endpackage

// ===== rtl/polygon_newell_normal_centroid.sv =====
// ----------------------------------------------------------------------------
// polygon_newell_normal_centroid
// Newell face normal (unit, Q1.14) and rounded centroid of polygons whose
// corners arrive one item at a time in winding order.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | input     | i_in_valid / o_in_ready | pos_x, pos_y, pos_z, last_corner
//  out     | output    | o_out_valid/i_out_ready | face_index, normal_*, center_*,
//          |           |                         | corner_total, flags
//
//  Corner: decide only (first corner, or one beyond the limit), or decide,
//  three Newell terms through the shared 32x32 multiplier, update.
//  Last corner: closing edge, clear, normalise, squares, root, six 48-step
//  divisions, load; a zero normal goes to the centroid ones, overflow to load.
//  Synchronous active-low reset clears counters and sums; no clearing pass.
//  A waiting result does not block corners; the next face end stalls on it.
// ----------------------------------------------------------------------------
module polygon_newell_normal_centroid
    import pnnc_pkg::*;
#(
    parameter int MAX_CORNERS = MAX_CORNERS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic signed [POS_W-1:0]  i_pos_x,
    input  logic signed [POS_W-1:0]  i_pos_y,
    input  logic signed [POS_W-1:0]  i_pos_z,
    input  logic                     i_last_corner,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [FACE_W-1:0]        o_face_index,
    output logic signed [NRM_W-1:0]  o_normal_x,
    output logic signed [NRM_W-1:0]  o_normal_y,
    output logic signed [NRM_W-1:0]  o_normal_z,
    output logic signed [POS_W-1:0]  o_center_x,
    output logic signed [POS_W-1:0]  o_center_y,
    output logic signed [POS_W-1:0]  o_center_z,
    output logic [TOT_W-1:0]         o_corner_total,
    output logic                     o_too_few_corners,
    output logic                     o_count_overflow
);

    t_cmd cmd;   // controller to datapath
    t_sts sts;   // datapath to controller

    pnnc_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_last_corner (i_last_corner),
        .o_in_ready    (o_in_ready),
        .i_sts         (sts),
        .o_cmd         (cmd)
    );

    pnnc_dp #(
        .MAX_CORNERS (MAX_CORNERS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_pos_x           (i_pos_x),
        .i_pos_y           (i_pos_y),
        .i_pos_z           (i_pos_z),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_face_index      (o_face_index),
        .o_normal_x        (o_normal_x),
        .o_normal_y        (o_normal_y),
        .o_normal_z        (o_normal_z),
        .o_center_x        (o_center_x),
        .o_center_y        (o_center_y),
        .o_center_z        (o_center_z),
        .o_corner_total    (o_corner_total),
        .o_too_few_corners (o_too_few_corners),
        .o_count_overflow  (o_count_overflow)
    );

endmodule

// ===== rtl/pnnc_ctrl.sv =====
// ----------------------------------------------------------------------------
// pnnc_ctrl
// Sequencer: per-corner edge terms, then normalise, root and divisions.
// ----------------------------------------------------------------------------
module pnnc_ctrl
    import pnnc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_last_corner,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECIDE = 4'd1;
    localparam logic [3:0] S_MUL    = 4'd2;
    localparam logic [3:0] S_ACC    = 4'd3;
    localparam logic [3:0] S_UPD    = 4'd4;
    localparam logic [3:0] S_FIN    = 4'd5;
    localparam logic [3:0] S_NORM   = 4'd6;
    localparam logic [3:0] S_SQ     = 4'd7;
    localparam logic [3:0] S_SQACC  = 4'd8;
    localparam logic [3:0] S_SQRT   = 4'd9;
    localparam logic [3:0] S_DIVLD  = 4'd10;
    localparam logic [3:0] S_DIV    = 4'd11;
    localparam logic [3:0] S_DIVST  = 4'd12;
    localparam logic [3:0] S_OUT    = 4'd13;

    localparam logic [2:0] IDX_LAST_TERM = 3'd2;
    localparam logic [2:0] IDX_FIRST_CTR = 3'd3;
    localparam logic [2:0] IDX_LAST_DIV  = 3'(NUM_DIVS - 1);
    localparam logic [5:0] SQRT_LAST    = 6'(SQRT_STEPS - 1);
    localparam logic [5:0] DIV_LAST     = 6'(DIV_STEPS - 1);

    logic [3:0] r_state, n_state;
    logic [2:0] r_idx, n_idx;
    logic [5:0] r_step, n_step;
    logic       r_last, n_last;
    logic       r_close, n_close;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_step  <= '0;
            r_last  <= 1'b0;
            r_close <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_step  <= n_step;
            r_last  <= n_last;
            r_close <= n_close;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_step  = r_step;
        n_last  = r_last;
        n_close = r_close;
        o_cmd   = '0;
        o_cmd.idx        = r_idx;
        o_cmd.edge_first = r_close;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_last  = i_last_corner;
                    n_close = 1'b0;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_idx = '0;
                if (i_sts.cnt_zero) begin
                    o_cmd.first_ld = 1'b1;
                    n_state = r_last ? S_FIN : S_IDLE;
                end else if (i_sts.cnt_lt_max) begin
                    n_state = S_MUL;
                end else begin
                    o_cmd.cnt_sat = 1'b1;
                    n_state = r_last ? S_FIN : S_IDLE;
                end
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc_newell = 1'b1;
                if (r_idx != IDX_LAST_TERM) begin
                    n_idx   = r_idx + 3'd1;
                    n_state = S_MUL;
                end else begin
                    n_idx   = '0;
                    n_state = r_close ? S_FIN : S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                if (r_last) begin
                    n_close = 1'b1;
                    n_state = S_MUL;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_FIN: begin
                o_cmd.res_clr = 1'b1;
                if (i_sts.cnt_ovf) begin
                    n_state = S_OUT;
                end else if (i_sts.nsum_zero) begin
                    n_idx   = IDX_FIRST_CTR;
                    n_state = S_DIVLD;
                end else begin
                    o_cmd.mag_ld = 1'b1;
                    n_state = S_NORM;
                end
            end
            S_NORM: begin
                if (i_sts.norm_done) begin
                    o_cmd.sq_clr = 1'b1;
                    n_idx   = '0;
                    n_state = S_SQ;
                end else begin
                    o_cmd.norm_step = 1'b1;
                end
            end
            S_SQ: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_sq = 1'b1;
                n_state = S_SQACC;
            end
            S_SQACC: begin
                o_cmd.acc_sq = 1'b1;
                if (r_idx != IDX_LAST_TERM) begin
                    n_idx   = r_idx + 3'd1;
                    n_state = S_SQ;
                end else begin
                    n_step  = '0;
                    n_close = 1'b0;
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                // first cycle only seeds the root; the sum is final by now
                if (r_step == '0 && !r_close) begin
                    o_cmd.sqrt_init = 1'b1;
                    n_close = 1'b1;
                end else begin
                    o_cmd.sqrt_step = 1'b1;
                    if (r_step == SQRT_LAST) begin
                        n_idx   = '0;
                        n_state = S_DIVLD;
                    end else begin
                        n_step = r_step + 6'd1;
                    end
                end
            end
            S_DIVLD: begin
                o_cmd.div_ld = 1'b1;
                n_step  = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_step == DIV_LAST) begin
                    n_state = S_DIVST;
                end else begin
                    n_step = r_step + 6'd1;
                end
            end
            S_DIVST: begin
                o_cmd.div_store = 1'b1;
                if (r_idx == IDX_LAST_DIV) begin
                    n_state = S_OUT;
                end else begin
                    n_idx   = r_idx + 3'd1;
                    n_state = S_DIVLD;
                end
            end
            S_OUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/pnnc_dp.sv =====
// ----------------------------------------------------------------------------
// pnnc_dp
// Datapath: corner store, sums, shared multiplier, root, divider, output.
// ----------------------------------------------------------------------------
module pnnc_dp
    import pnnc_pkg::*;
#(
    parameter int MAX_CORNERS = MAX_CORNERS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic signed [POS_W-1:0]  i_pos_x,
    input  logic signed [POS_W-1:0]  i_pos_y,
    input  logic signed [POS_W-1:0]  i_pos_z,
    input  t_cmd                     i_cmd,
    output t_sts                     o_sts,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [FACE_W-1:0]        o_face_index,
    output logic signed [NRM_W-1:0]  o_normal_x,
    output logic signed [NRM_W-1:0]  o_normal_y,
    output logic signed [NRM_W-1:0]  o_normal_z,
    output logic signed [POS_W-1:0]  o_center_x,
    output logic signed [POS_W-1:0]  o_center_y,
    output logic signed [POS_W-1:0]  o_center_z,
    output logic [TOT_W-1:0]         o_corner_total,
    output logic                     o_too_few_corners,
    output logic                     o_count_overflow
);

    localparam int CNT_W = $clog2(MAX_CORNERS + 2);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CORNERS);

    t_pos                     r_cur [3];
    t_pos                     r_first [3];
    t_pos                     r_prev [3];
    logic [NSUM_W-1:0]        r_nsum [3];
    logic [CSUM_W-1:0]        r_csum [3];
    logic [NSUM_W-1:0]        r_mag [3];
    logic                     r_neg [3];
    logic [CNT_W-1:0]         r_count;
    logic [FACE_W-1:0]        r_face;
    logic signed [PROD_W-1:0] r_prod;
    logic [SQ_W-1:0]          r_sq;
    logic [ROOT_W-1:0]        r_sqn, r_root, r_bit;
    logic [NUM_W-1:0]         r_num, r_quo;
    logic [DEN_W-1:0]         r_rem, r_den;
    logic                     r_dneg;
    logic signed [NRM_W-1:0]  r_nrm [3];
    logic signed [POS_W-1:0]  r_ctr [3];
    logic                     r_out_valid;

    function automatic logic [1:0] f_diff_idx(input logic [1:0] k);
        unique case (k)
            2'd0:    return 2'd1;
            2'd1:    return 2'd2;
            default: return 2'd0;
        endcase
    endfunction

    function automatic logic [1:0] f_sum_idx(input logic [1:0] k);
        unique case (k)
            2'd0:    return 2'd2;
            2'd1:    return 2'd0;
            default: return 2'd1;
        endcase
    endfunction

    // ---- shared multiplier operands
    logic [1:0]               k, kd, ks;
    t_pos                     ea_d, ea_s, eb_d, eb_s;
    logic signed [POS_W:0]    e_diff, e_sum;
    logic signed [MUL_W-1:0]  op_a, op_b;
    logic signed [PROD_W-1:0] product;

    always_comb begin
        k    = i_cmd.idx[1:0];
        kd   = f_diff_idx(k);
        ks   = f_sum_idx(k);
        ea_d = r_prev[kd];
        ea_s = r_prev[ks];
        eb_d = i_cmd.edge_first ? r_first[kd] : r_cur[kd];
        eb_s = i_cmd.edge_first ? r_first[ks] : r_cur[ks];
        e_diff = (POS_W+1)'(ea_d) - (POS_W+1)'(eb_d);
        e_sum  = (POS_W+1)'(ea_s) + (POS_W+1)'(eb_s);
        if (i_cmd.mul_sq) begin
            op_a = signed'(MUL_W'(r_mag[k][MAG_SIG_W-1:0]));
            op_b = op_a;
        end else begin
            op_a = MUL_W'(e_diff);
            op_b = MUL_W'(e_sum);
        end
        product = PROD_W'(op_a) * PROD_W'(op_b);
    end

    // ---- normalisation status
    logic any_hi, any_29;
    always_comb begin
        any_hi = 1'b0;
        any_29 = 1'b0;
        for (int i = 0; i < 3; i++) begin
            any_hi = any_hi | (|r_mag[i][NSUM_W-1:MAG_SIG_W]);
            any_29 = any_29 | (|r_mag[i][NSUM_W-1:MAG_SIG_W-1]);
        end
    end

    // ---- root step
    logic [ROOT_W-1:0] rt_trial;
    logic              rt_ge;
    assign rt_trial = r_root + r_bit;
    assign rt_ge    = r_sqn >= rt_trial;

    // ---- divider step
    logic [DEN_W:0] dv_rem2;
    logic           dv_ge;
    assign dv_rem2 = {r_rem, r_num[NUM_W-1]};
    assign dv_ge   = dv_rem2 >= {1'b0, r_den};

    // ---- divider load operands
    logic [1:0]          dj;
    logic [CSUM_W-1:0]   cs;
    logic [CSUM_W:0]     cs_mag;
    logic [DEN_W-1:0]    len;
    logic [CNTX_W-1:0]   cntx;
    always_comb begin
        dj     = (i_cmd.idx < 3'd3) ? i_cmd.idx[1:0] : 2'(i_cmd.idx - 3'd3);
        cs     = r_csum[dj];
        cs_mag = cs[CSUM_W-1] ? ((CSUM_W+1)'(0) - {1'b1, cs}) : {1'b0, cs};
        len    = r_root[DEN_W-1:0];
        cntx   = CNTX_W'(r_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_face      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_first[i] <= '0;
                r_prev[i]  <= '0;
                r_nsum[i]  <= '0;
                r_csum[i]  <= '0;
            end
        end else begin
            if (i_cmd.first_ld) begin
                for (int i = 0; i < 3; i++) begin
                    r_first[i] <= r_cur[i];
                    r_prev[i]  <= r_cur[i];
                    r_nsum[i]  <= '0;
                    r_csum[i]  <= CSUM_W'(r_cur[i]);
                end
                r_count <= CNT_W'(1);
            end
            if (i_cmd.acc_newell) begin
                r_nsum[k] <= r_nsum[k] + r_prod[NSUM_W-1:0];
            end
            if (i_cmd.upd) begin
                for (int i = 0; i < 3; i++) begin
                    r_csum[i] <= r_csum[i] + CSUM_W'(r_cur[i]);
                    r_prev[i] <= r_cur[i];
                end
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.cnt_sat) begin
                r_count <= CNT_MAX + CNT_W'(1);
            end
            if (i_cmd.emit) begin
                r_count <= '0;
                r_face  <= r_face + FACE_W'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cur[0] <= i_pos_x;
            r_cur[1] <= i_pos_y;
            r_cur[2] <= i_pos_z;
        end
        if (i_cmd.mul_en) begin
            r_prod <= product;
        end
        if (i_cmd.mag_ld) begin
            for (int i = 0; i < 3; i++) begin
                r_neg[i] <= r_nsum[i][NSUM_W-1];
                r_mag[i] <= r_nsum[i][NSUM_W-1] ? (NSUM_W'(0) - r_nsum[i]) : r_nsum[i];
            end
        end
        if (i_cmd.norm_step) begin
            for (int i = 0; i < 3; i++) begin
                if (any_hi) begin
                    r_mag[i] <= r_mag[i] >> 1;
                end else if (!any_29) begin
                    r_mag[i] <= r_mag[i] << 1;
                end
            end
        end
        if (i_cmd.sq_clr) begin
            r_sq <= '0;
        end
        if (i_cmd.acc_sq) begin
            r_sq <= r_sq + r_prod[SQ_W-1:0];
        end
        if (i_cmd.sqrt_init) begin
            r_sqn  <= ROOT_W'(r_sq);
            r_root <= '0;
            r_bit  <= ROOT_W'(1) << (2 * (SQRT_STEPS - 1));
        end
        if (i_cmd.sqrt_step) begin
            if (rt_ge) begin
                r_sqn  <= r_sqn - rt_trial;
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (i_cmd.div_ld) begin
            r_rem <= '0;
            r_quo <= '0;
            if (i_cmd.idx < 3'd3) begin
                r_num  <= (NUM_W'(r_mag[dj][MAG_SIG_W-1:0]) << NRM_FRAC)
                          + NUM_W'(len >> 1);
                r_den  <= len;
                r_dneg <= r_neg[dj];
            end else begin
                r_num  <= NUM_W'(cs_mag) + NUM_W'(cntx >> 1);
                r_den  <= DEN_W'(cntx);
                r_dneg <= cs[CSUM_W-1];
            end
        end
        if (i_cmd.div_step) begin
            r_rem <= dv_ge ? DEN_W'(dv_rem2 - {1'b0, r_den}) : dv_rem2[DEN_W-1:0];
            r_num <= r_num << 1;
            r_quo <= {r_quo[NUM_W-2:0], dv_ge};
        end
        if (i_cmd.res_clr) begin
            for (int i = 0; i < 3; i++) begin
                r_nrm[i] <= '0;
                r_ctr[i] <= '0;
            end
        end
        if (i_cmd.div_store) begin
            if (i_cmd.idx < 3'd3) begin
                r_nrm[dj] <= r_dneg ? (NRM_W'(0) - r_quo[NRM_W-1:0]) : r_quo[NRM_W-1:0];
            end else begin
                r_ctr[dj] <= r_dneg ? (POS_W'(0) - r_quo[POS_W-1:0]) : r_quo[POS_W-1:0];
            end
        end
        if (i_cmd.emit) begin
            o_face_index      <= r_face;
            o_normal_x        <= r_nrm[0];
            o_normal_y        <= r_nrm[1];
            o_normal_z        <= r_nrm[2];
            o_center_x        <= r_ctr[0];
            o_center_y        <= r_ctr[1];
            o_center_z        <= r_ctr[2];
            o_corner_total    <= (cntx > CNTX_W'(255)) ? 8'hFF : cntx[TOT_W-1:0];
            o_too_few_corners <= cntx < CNTX_W'(3);
            o_count_overflow  <= r_count > CNT_MAX;
        end
    end

    assign o_out_valid = r_out_valid;

    always_comb begin
        o_sts.cnt_zero   = (r_count == '0);
        o_sts.cnt_lt_max = (r_count < CNT_MAX);
        o_sts.cnt_ovf    = (r_count > CNT_MAX);
        o_sts.nsum_zero  = (r_nsum[0] == '0) && (r_nsum[1] == '0) && (r_nsum[2] == '0);
        o_sts.norm_done  = !any_hi && any_29;
        o_sts.out_busy   = r_out_valid && !i_out_ready;
    end

endmodule
